@@ rtl/sdps_pkg.sv @@
package sdps_pkg;

   localparam int DIFF_W = 33;
   localparam int R2_W   = 66;
   localparam int ROOT_W = 33;
   localparam int NUM_W  = 64;
   localparam int DEN_W  = 37;
   localparam int K_W    = 40;
   localparam int TERM_W = 42;
   localparam int POT_W  = 48;

   localparam logic [1:0] CMD_STORE = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   localparam logic [1:0] REG_SOFTENING  = 2'd0;
   localparam logic [1:0] REG_PAIR_SCALE = 2'd1;

   localparam logic [31:0] SOFTENING_RESET  = 32'd11744;
   localparam logic [31:0] PAIR_SCALE_RESET = 32'd6930891;

   // kernel coefficients, Q.28
   localparam logic [32:0] Q28_16_3  = 33'd1431655765;
   localparam logic [32:0] Q28_48_5  = 33'd2576980378;
   localparam logic [32:0] Q28_32_5  = 33'd1717986918;
   localparam logic [32:0] Q28_32_3  = 33'd2863311531;
   localparam logic [32:0] Q28_16    = 33'd4294967296;
   localparam logic [32:0] Q28_32_15 = 33'd572662306;
   // constant terms, Q.32
   localparam logic signed [K_W-1:0] Q32_14_5 = 40'sd12025908429;
   localparam logic signed [K_W-1:0] Q32_16_5 = 40'sd13743895347;

   localparam longint POT_MAX = 64'sd140737488355327;
   localparam longint POT_MIN = -64'sd140737488355328;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } pos_type;

   typedef struct packed {
      logic              start;
      logic [DIFF_W-1:0] dx;
      logic [DIFF_W-1:0] dy;
      logic [DIFF_W-1:0] dz;
   } kern_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [TERM_W-1:0] term;
   } kern_rsp_type;

   typedef enum logic [2:0] {
      T_IDLE, T_TGT_RD, T_TGT_CAP, T_PAIR_RD, T_PAIR_GO, T_PAIR_WAIT, T_FINISH
   } tstate_type;

   typedef enum logic [3:0] {
      KS_IDLE, KS_SQ, KS_ROOT, KS_PICK, KS_DIV_U, KS_DIV_INV, KS_DIV_OUT,
      KS_POW, KS_TERM, KS_SCALE0, KS_SCALE1
   } kstate_type;

endpackage

@@ rtl/sdps_mem.sv @@
module sdps_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  sdps_pkg::pos_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output sdps_pkg::pos_type rd_data
);
   import sdps_pkg::*;

   pos_type mem [DEPTH];
   pos_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sdps_div.sv @@
module sdps_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sdps_pkg::NUM_W-1:0] num,
   input  logic [sdps_pkg::DEN_W-1:0] den,
   output logic                       done,
   output logic [sdps_pkg::NUM_W-1:0] quot
);
   import sdps_pkg::*;

   localparam int CW = $clog2(NUM_W);

   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [NUM_W-1:0] q_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   rem_sh;
   logic             ge;

   assign rem_sh = {rem_ff, q_ff[NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CW'(NUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         q_ff   <= num;
         den_ff <= den;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
         q_ff   <= {q_ff[NUM_W-2:0], ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

@@ rtl/sdps_kernel.sv @@
module sdps_kernel (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            eps,
   input  logic [31:0]            scale,
   input  sdps_pkg::kern_req_type kreq,
   output sdps_pkg::kern_rsp_type krsp
);
   import sdps_pkg::*;

   kstate_type state_ff, state_in;
   logic [5:0]               cnt_ff;
   logic [DIFF_W-1:0]        dx_ff, dy_ff, dz_ff;
   logic [R2_W-1:0]          r2_ff;
   logic [ROOT_W-1:0]        root_ff;
   logic [35:0]              rem_ff;
   logic                     mid_ff;
   logic [31:0]              u_ff, p_ff, u2_ff, u3_ff, u4_ff, u5_ff;
   logic signed [K_W-1:0]    k_ff;
   logic [55:0]              hi_ff;
   logic [15:0]              mlo_ff;
   logic                     neg_ff;
   logic signed [TERM_W-1:0] term_ff;
   logic                     done_ff;

   logic             div_start, div_done;
   logic [NUM_W-1:0] div_num, div_quot;
   logic [DEN_W-1:0] div_den;

   logic [DIFF_W-1:0] sq_op;
   logic [R2_W-1:0]   sq;
   logic [35:0]       rem_sh;
   logic [35:0]       trial;
   logic              inner, half;
   logic [63:0]       pw_prod;
   logic [32:0]       coef;
   logic [31:0]       pw;
   logic              sub, last_term;
   logic [64:0]       tprod;
   logic [K_W-1:0]    mag;
   logic [47:0]       lo_prod;
   logic [56:0]       csum;
   logic [TERM_W-1:0] cmag;

   sdps_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    sq_op = dx_ff;
         2'd1:    sq_op = dy_ff;
         default: sq_op = dz_ff;
      endcase
   end
   assign sq      = sq_op * sq_op;
   assign rem_sh  = {rem_ff[33:0], r2_ff[R2_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign inner   = root_ff < {1'b0, eps};
   assign half    = {root_ff, 1'b0} < {2'b0, eps};
   assign pw_prod = p_ff * u_ff;
   assign mag     = k_ff[K_W-1] ? K_W'(-k_ff) : K_W'(k_ff);
   assign lo_prod = scale * mlo_ff;
   assign csum    = {1'b0, hi_ff} + 57'(lo_prod[47:16]);
   assign cmag    = TERM_W'(csum[56:16]);

   // term selection for the polynomial pieces
   always_comb begin
      if (mid_ff) begin
         case (cnt_ff[1:0])
            2'd0:    begin coef = Q28_32_3;  pw = u2_ff; sub = 1'b0; end
            2'd1:    begin coef = Q28_16;    pw = u3_ff; sub = 1'b1; end
            2'd2:    begin coef = Q28_48_5;  pw = u4_ff; sub = 1'b0; end
            default: begin coef = Q28_32_15; pw = u5_ff; sub = 1'b1; end
         endcase
         last_term = cnt_ff == 6'd3;
      end else begin
         case (cnt_ff[1:0])
            2'd0:    begin coef = Q28_16_3; pw = u2_ff; sub = 1'b0; end
            2'd1:    begin coef = Q28_48_5; pw = u4_ff; sub = 1'b1; end
            default: begin coef = Q28_32_5; pw = u5_ff; sub = 1'b0; end
         endcase
         last_term = cnt_ff == 6'd2;
      end
   end
   assign tprod = coef * pw;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_num   = {eps, 32'b0};
      div_den   = DEN_W'(root_ff);
      unique case (state_ff)
         KS_IDLE:    if (kreq.start) state_in = KS_SQ;
         KS_SQ:      if (cnt_ff == 6'd2) state_in = KS_ROOT;
         KS_ROOT:    if (cnt_ff == 6'd32) state_in = KS_PICK;
         KS_PICK: begin
            if (inner) begin
               div_start = 1'b1;
               div_num   = {root_ff[31:0], 32'b0};
               div_den   = DEN_W'(eps);
               state_in  = KS_DIV_U;
            end else if (root_ff == '0) begin
               state_in = KS_SCALE0;
            end else begin
               div_start = 1'b1;
               state_in  = KS_DIV_OUT;
            end
         end
         KS_DIV_U: begin
            if (div_done) begin
               if (mid_ff) begin
                  div_start = 1'b1;
                  div_den   = {root_ff, 4'b0} - {4'b0, root_ff};
                  state_in  = KS_DIV_INV;
               end else begin
                  state_in = KS_POW;
               end
            end
         end
         KS_DIV_INV: if (div_done) state_in = KS_POW;
         KS_DIV_OUT: if (div_done) state_in = KS_SCALE0;
         KS_POW:     if (cnt_ff == 6'd3) state_in = KS_TERM;
         KS_TERM:    if (last_term) state_in = KS_SCALE0;
         KS_SCALE0:  state_in = KS_SCALE1;
         KS_SCALE1:  state_in = KS_IDLE;
         default:    state_in = KS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= state_ff == KS_SCALE1;
      end
      cnt_ff <= (state_in != state_ff) ? 6'd0 : cnt_ff + 1'b1;
      case (state_ff)
         KS_IDLE: begin
            dx_ff   <= kreq.dx;
            dy_ff   <= kreq.dy;
            dz_ff   <= kreq.dz;
            r2_ff   <= '0;
            root_ff <= '0;
            rem_ff  <= '0;
         end
         KS_SQ: r2_ff <= r2_ff + sq;
         KS_ROOT: begin
            r2_ff <= {r2_ff[R2_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         KS_PICK: begin
            mid_ff <= !half;
            k_ff   <= '0;
         end
         KS_DIV_U: begin
            if (div_done) begin
               u_ff <= div_quot[31:0];
               p_ff <= div_quot[31:0];
               k_ff <= -Q32_14_5;
            end
         end
         KS_DIV_INV: if (div_done) k_ff <= $signed(K_W'(div_quot[31:0])) - Q32_16_5;
         KS_DIV_OUT: if (div_done) k_ff <= -$signed(K_W'(div_quot[32:0]));
         KS_POW: begin
            p_ff <= pw_prod[63:32];
            case (cnt_ff[1:0])
               2'd0:    u2_ff <= pw_prod[63:32];
               2'd1:    u3_ff <= pw_prod[63:32];
               2'd2:    u4_ff <= pw_prod[63:32];
               default: u5_ff <= pw_prod[63:32];
            endcase
         end
         KS_TERM: begin
            if (sub) k_ff <= k_ff - $signed(K_W'(tprod[64:28]));
            else     k_ff <= k_ff + $signed(K_W'(tprod[64:28]));
         end
         KS_SCALE0: begin
            hi_ff  <= scale * mag[K_W-1:16];
            mlo_ff <= mag[15:0];
            neg_ff <= k_ff[K_W-1];
         end
         KS_SCALE1: term_ff <= neg_ff ? $signed(-cmag) : $signed(cmag);
         default: ;
      endcase
   end

   assign krsp.done = done_ff;
   assign krsp.term = term_ff;

endmodule

@@ rtl/softened_direct_potential_sum.sv @@
// Softened direct-sum potential engine. Store transactions append a particle
// position (signed Q10.22) to an on-chip table of MAX_PARTICLES entries;
// clear empties the table; a query names a stored particle and returns the
// saturated Q31.16 sum, over every stored particle including itself, of
// pair_scale times the cubic-spline softened kernel of their distance. A query
// walks the table one pair at a time through a single shared kernel unit. Each
// pair passes through the table read and hand-off, the squared distance and a
// 33-step square root, then one 64-step divide for the outer piece, one divide
// plus the polynomial for the inner piece, or two divides plus the polynomial
// for the middle piece. A coincident pair at zero softening length skips the
// divide. The particle table needs no initialization after reset. Write the
// softening length and pair scale only while no transaction is in flight.
module softened_direct_potential_sum #(
   parameter int MAX_PARTICLES = 4096,
   localparam int AW    = $clog2(MAX_PARTICLES),
   localparam int CNT_W = $clog2(MAX_PARTICLES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_command,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic [AW-1:0]       req_target_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [47:0]  rsp_potential,
   output logic [1:0]          rsp_status,
   output logic [CNT_W-1:0]    rsp_loaded_count,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata
);
   import sdps_pkg::*;

   localparam int ACC_W = TERM_W + CNT_W;
   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(POT_MAX);
   localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(POT_MIN);

   tstate_type state_ff, state_in;

   logic [31:0]             eps_ff;
   logic [31:0]             scale_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [AW-1:0]           tgt_ff;
   logic [CNT_W-1:0]        j_ff;
   logic signed [ACC_W-1:0] acc_ff;
   pos_type                 tpos_ff;
   logic                    rsp_valid_ff;
   logic signed [47:0]      rsp_potential_ff;
   logic [1:0]              rsp_status_ff;
   logic [CNT_W-1:0]        rsp_count_ff;

   logic         accept;
   logic         has_room;
   logic         slot_free;
   logic         mem_wr_en;
   logic         mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   pos_type      wr_pos;
   pos_type      rd_pos;
   kern_req_type kreq;
   kern_rsp_type krsp;
   logic         last_pair;
   logic signed [47:0] pot_sat;

   // an output slot that is empty, or being emptied this cycle, takes a result
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == T_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign has_room  = count_ff < CNT_W'(MAX_PARTICLES);
   assign last_pair = CNT_W'(j_ff + 1'b1) == count_ff;

   assign wr_pos    = '{x: req_pos_x, y: req_pos_y, z: req_pos_z};
   assign mem_wr_en = accept && (req_command == CMD_STORE) && has_room;

   sdps_mem #(
      .DEPTH (MAX_PARTICLES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_pos),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_pos)
   );

   function automatic logic [DIFF_W-1:0] abs_diff(logic [31:0] a, logic [31:0] b);
      logic [DIFF_W-1:0] d;
      d = {a[31], a} - {b[31], b};
      return d[DIFF_W-1] ? DIFF_W'(-d) : d;
   endfunction

   assign kreq.start = state_ff == T_PAIR_GO;
   assign kreq.dx    = abs_diff(tpos_ff.x, rd_pos.x);
   assign kreq.dy    = abs_diff(tpos_ff.y, rd_pos.y);
   assign kreq.dz    = abs_diff(tpos_ff.z, rd_pos.z);

   sdps_kernel u_kernel (
      .clock (clock),
      .reset (reset),
      .eps   (eps_ff),
      .scale (scale_ff),
      .kreq  (kreq),
      .krsp  (krsp)
   );

   // clamp the exact sum into the 48-bit result range
   always_comb begin
      if (acc_ff > ACC_MAX)      pot_sat = 48'(ACC_MAX);
      else if (acc_ff < ACC_MIN) pot_sat = 48'(ACC_MIN);
      else                       pot_sat = 48'(acc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // query sequencer: fetch the target once, then one table entry per pair
   always_comb begin
      state_in    = state_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = j_ff[AW-1:0];
      unique case (state_ff)
         T_IDLE: begin
            if (accept && req_command == CMD_QUERY &&
                CNT_W'(req_target_index) < count_ff) begin
               state_in = T_TGT_RD;
            end
         end
         T_TGT_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = tgt_ff;
            state_in    = T_TGT_CAP;
         end
         T_TGT_CAP: state_in = T_PAIR_RD;
         T_PAIR_RD: begin
            mem_rd_en = 1'b1;
            state_in  = T_PAIR_GO;
         end
         T_PAIR_GO: state_in = T_PAIR_WAIT;
         T_PAIR_WAIT: begin
            if (krsp.done) state_in = last_pair ? T_FINISH : T_PAIR_RD;
         end
         T_FINISH: if (slot_free) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff       <= SOFTENING_RESET;
         scale_ff     <= PAIR_SCALE_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_SOFTENING:  eps_ff   <= csr_wdata;
               REG_PAIR_SCALE: scale_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            if (req_command == CMD_STORE && has_room) count_ff <= count_ff + 1'b1;
            if (req_command == CMD_CLEAR) count_ff <= '0;
            if (req_command == CMD_QUERY && CNT_W'(req_target_index) < count_ff) begin
               rsp_valid_ff <= rsp_valid_ff && !rsp_ready;
            end
         end
         if (state_ff == T_FINISH && slot_free) rsp_valid_ff <= 1'b1;
      end

      // immediate result of store, clear and no-op; a failed query too
      if (accept) begin
         rsp_potential_ff <= '0;
         rsp_status_ff    <= ST_OK;
         tgt_ff           <= req_target_index;
         j_ff             <= '0;
         acc_ff           <= '0;
         case (req_command)
            CMD_STORE: begin
               if (has_room) rsp_count_ff <= count_ff + 1'b1;
               else begin
                  rsp_status_ff <= ST_FULL;
                  rsp_count_ff  <= count_ff;
               end
            end
            CMD_QUERY: begin
               rsp_count_ff <= count_ff;
               if (CNT_W'(req_target_index) >= count_ff) rsp_status_ff <= ST_MISSING;
            end
            CMD_CLEAR: rsp_count_ff <= '0;
            default:   rsp_count_ff <= count_ff;
         endcase
      end

      if (state_ff == T_TGT_CAP) tpos_ff <= rd_pos;
      if (state_ff == T_PAIR_WAIT && krsp.done) begin
         acc_ff <= acc_ff + ACC_W'(krsp.term);
         j_ff   <= j_ff + 1'b1;
      end
      if (state_ff == T_FINISH && slot_free) begin
         rsp_potential_ff <= pot_sat;
         rsp_status_ff    <= ST_OK;
         rsp_count_ff     <= count_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_potential    = rsp_potential_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_loaded_count = rsp_count_ff;

   // a pair result only lands while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      krsp.done |-> state_ff == T_PAIR_WAIT)
      else $error("kernel result outside pair wait");

   // the walk never fetches past the loaded entries
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == T_PAIR_RD |-> j_ff < count_ff)
      else $error("pair index beyond loaded count");

   // the table never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      accept |=> count_ff <= CNT_W'(MAX_PARTICLES))
      else $error("particle count above capacity");

endmodule

@@ sim/softened_direct_potential_sum_tb.sv @@
`timescale 1ns / 1ps

module softened_direct_potential_sum_tb;
   import sdps_pkg::*;

   localparam int DEPTH = 4096;

   // register indexes with no register behind them
   localparam logic [1:0] REG_SPARE_A = 2'd2;
   localparam logic [1:0] REG_SPARE_B = 2'd3;

   // Result fields as the block reports them.
   typedef struct {
      logic signed [47:0] potential;
      logic [1:0]         status;
      logic [12:0]        count;
   } pot_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_command = CMD_NOP;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic [11:0]        req_target_index = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [47:0] rsp_potential;
   logic [1:0]         rsp_status;
   logic [12:0]        rsp_loaded_count;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = REG_SOFTENING;
   logic [31:0]        csr_wdata = '0;

   // Shadow copy of the particle table and registers.
   logic [31:0] px_table [DEPTH];
   logic [31:0] py_table [DEPTH];
   logic [31:0] pz_table [DEPTH];
   logic [12:0] stored_count;
   logic [31:0] eps_reg;
   logic [31:0] scale_reg;

   pot_result_type pending_results[$];
   int          errors = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;

   softened_direct_potential_sum DUT (.*);

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver backpressure, changed on the falling edge only.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // floor(sqrt) of a 66-bit squared distance, two bits per step
   function automatic logic [32:0] root66(logic [65:0] v);
      logic [69:0] rem;
      logic [69:0] trial;
      logic [32:0] root;
      rem = '0;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
         rem = (rem << 2) | v[2*i +: 2];
         trial = {35'b0, root, 2'b01};
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 1'b1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic longint coef_term(logic [32:0] coef, logic [127:0] p);
      logic [127:0] prod;
      prod = {95'b0, coef} * p;
      return longint'(prod >> 28);
   endfunction

   // Spline-softened kernel in signed Q.32
   function automatic longint kernel_q32(logic [32:0] r);
      logic [127:0] e, rr, u, u2, u3, u4, u5, q;
      e = {96'b0, eps_reg};
      rr = {95'b0, r};
      if (rr < e) begin
         u  = (rr << 32) / e;
         u2 = (u * u) >> 32;
         u3 = (u2 * u) >> 32;
         u4 = (u3 * u) >> 32;
         u5 = (u4 * u) >> 32;
         if ((rr << 1) < e)
            return coef_term(Q28_16_3, u2) - coef_term(Q28_48_5, u4)
                 + coef_term(Q28_32_5, u5) - longint'(Q32_14_5);
         q = (e << 32) / (rr * 15);
         return longint'(q[63:0]) + coef_term(Q28_32_3, u2) - coef_term(Q28_16, u3)
              + coef_term(Q28_48_5, u4) - coef_term(Q28_32_15, u5)
              - longint'(Q32_16_5);
      end
      if (rr == 0) return 0;
      q = (e << 32) / rr;
      return -longint'(q[63:0]);
   endfunction

   // Scale one kernel value into a Q.16 pair contribution, 64-bit wrapping
   function automatic longint scaled_pair(longint k);
      logic [63:0] m, s, a, b, c;
      m = (k < 0) ? 64'(-k) : 64'(k);
      s = {32'b0, scale_reg};
      a = s * (m >> 16);
      b = (s * (m & 64'hFFFF)) >> 16;
      c = (a + b) >> 16;
      return (k < 0) ? -longint'(c) : longint'(c);
   endfunction

   function automatic longint pair_potential(int i, int j);
      longint dx, dy, dz;
      logic [65:0] r2;
      dx = longint'($signed(px_table[i])) - longint'($signed(px_table[j]));
      dy = longint'($signed(py_table[i])) - longint'($signed(py_table[j]));
      dz = longint'($signed(pz_table[i])) - longint'($signed(pz_table[j]));
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dz < 0) dz = -dz;
      r2 = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
      return scaled_pair(kernel_q32(root66(r2)));
   endfunction

   // Apply one accepted transaction to the shadow state; return its result.
   function automatic pot_result_type apply_command(logic [1:0] cmd, logic [31:0] x,
                                                    logic [31:0] y, logic [31:0] z,
                                                    logic [11:0] tgt);
      pot_result_type res;
      longint      sum;
      res.potential = '0;
      res.status = ST_OK;
      sum = 0;
      case (cmd)
         CMD_STORE: begin
            if (stored_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               px_table[stored_count] = x;
               py_table[stored_count] = y;
               pz_table[stored_count] = z;
               stored_count++;
            end
         end
         CMD_QUERY: begin
            if (tgt >= stored_count) begin
               res.status = ST_MISSING;
            end else begin
               for (int j = 0; j < stored_count; j++) sum += pair_potential(tgt, j);
               if (sum > POT_MAX) sum = POT_MAX;
               if (sum < POT_MIN) sum = POT_MIN;
               res.potential = sum[47:0];
            end
         end
         CMD_CLEAR: stored_count = '0;
         default: ;
      endcase
      res.count = stored_count;
      return res;
   endfunction

   // Drive one transaction, hold it until accepted, then record the expected result.
   task automatic send_command(logic [1:0] cmd, logic [31:0] x = '0, logic [31:0] y = '0,
                               logic [31:0] z = '0, logic [11:0] tgt = '0);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_command = cmd;
      req_pos_x = x;
      req_pos_y = y;
      req_pos_z = z;
      req_target_index = tgt;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_command(cmd, x, y, z, tgt));
   endtask

   // Drop valid and wait until every outstanding result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == REG_SOFTENING) eps_reg = value;
      else if (idx == REG_PAIR_SCALE) scale_reg = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic set_config(logic [31:0] eps, logic [31:0] scale);
      drain_results();
      write_csr(REG_SOFTENING, eps);
      write_csr(REG_PAIR_SCALE, scale);
   endtask

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      pot_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_potential !== want.potential) begin
               $error("potential: expected %0d got %0d", want.potential, rsp_potential);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_loaded_count !== want.count) begin
               $error("loaded_count: expected %0d got %0d", want.count, rsp_loaded_count);
               errors++;
            end
         end
      end
   end

   // Position near a cluster center at a random scale, so every kernel piece shows up.
   function automatic logic [31:0] near(logic [31:0] center);
      logic signed [31:0] off;
      off = $signed($urandom) >>> $urandom_range(31, 8);
      return center + off;
   endfunction

   task automatic test_directed();
      // extremes of position and both ends of the table
      send_command(CMD_QUERY, '0, '0, '0, 12'd0);
      send_command(CMD_STORE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_command(CMD_STORE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_command(CMD_STORE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_command(CMD_STORE, 32'd0, 32'd1000, 32'hFFFF_F000);
      send_command(CMD_STORE, 32'd3000, 32'd1000, 32'hFFFF_F000);
      send_command(CMD_STORE, 32'd9000, 32'd1000, 32'hFFFF_F000);
      send_command(CMD_STORE, 32'd20000, 32'd1000, 32'hFFFF_F000);
      send_command(CMD_QUERY, '0, '0, '0, 12'd0);
      send_command(CMD_QUERY, '0, '0, '0, 12'd2);
      send_command(CMD_QUERY, '0, '0, '0, 12'd3);
      send_command(CMD_QUERY, '0, '0, '0, 12'd6);
      send_command(CMD_QUERY, '0, '0, '0, 12'd7);
      send_command(CMD_QUERY, '0, '0, '0, 12'hFFF);
      send_command(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
      send_command(CMD_CLEAR, 32'hFFFF_FFFF, '0, '0, 12'hFFF);
      send_command(CMD_QUERY, '0, '0, '0, 12'd0);
   endtask

   task automatic small_cluster_queries();
      logic [31:0] c;
      c = $urandom;
      send_command(CMD_CLEAR);
      for (int i = 0; i < 4; i++) send_command(CMD_STORE, near(c), near(c), near(c));
      send_command(CMD_STORE, c, c, c);
      send_command(CMD_STORE, c, c, c);
      send_command(CMD_QUERY, '0, '0, '0, 12'd4);
      send_command(CMD_QUERY, '0, '0, '0, 12'd1);
   endtask

   task automatic test_register_extremes();
      set_config(32'd1, 32'hFFFF_FFFF);
      small_cluster_queries();
      set_config(32'hFFFF_FFFF, 32'd0);
      small_cluster_queries();
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      small_cluster_queries();
      // zero softening: outer piece everywhere, coincident pairs give nothing
      set_config(32'd0, 32'd65536);
      small_cluster_queries();
      // writes to unused indexes are ignored
      drain_results();
      write_csr(REG_SPARE_A, 32'd77);
      write_csr(REG_SPARE_B, 32'd99);
      small_cluster_queries();
   endtask

   task automatic test_random(int n_items);
      logic [31:0] c;
      int          pick;
      c = $urandom;
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(99);
         if (n % 12 == 11) drain_results();  // hold off until the block is empty
         if (stored_count >= 10 || pick < 5) begin
            send_command(CMD_CLEAR, $urandom, $urandom, $urandom, 12'($urandom));
            c = $urandom;
         end else if (pick < 8) begin
            send_command(CMD_NOP, $urandom, $urandom, $urandom, 12'($urandom));
         end else if (pick < 60) begin
            if (pick < 15) send_command(CMD_STORE, $urandom, $urandom, $urandom);
            else send_command(CMD_STORE, near(c), near(c), near(c), 12'($urandom));
         end else if (pick < 70) begin
            send_command(CMD_QUERY, $urandom, $urandom, $urandom, 12'($urandom));
         end else begin
            send_command(CMD_QUERY, '0, '0, '0,
                         12'($urandom_range(stored_count == 0 ? 0 : stored_count - 1)));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         px_table[i] = '0;
         py_table[i] = '0;
         pz_table[i] = '0;
      end
      stored_count = '0;
      eps_reg = SOFTENING_RESET;
      scale_reg = PAIR_SCALE_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_register_extremes();

      set_config($urandom_range(20000, 1000), $urandom);
      send_idle_pct = 37;
      rsp_stall_pct = 76;
      test_random(25);
      set_config($urandom_range(1 << 20, 1 << 12), $urandom);
      send_idle_pct = 76;
      rsp_stall_pct = 37;
      test_random(25);
      set_config(SOFTENING_RESET, PAIR_SCALE_RESET);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random(25);

      drain_results();
      repeat (50) @(posedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   // Watchdog
   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ softened_direct_potential_sum.f @@
rtl/sdps_pkg.sv
rtl/sdps_mem.sv
rtl/sdps_div.sv
rtl/sdps_kernel.sv
rtl/softened_direct_potential_sum.sv
sim/softened_direct_potential_sum_tb.sv
